// File: rtl/core/jdi_pkg.sv
// shared types and constants for the joystick direction / intensity block
// no dependencies
package jdi_pkg;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned SqrtCells  = 20;
  localparam int unsigned DivCells   = 13;
  localparam int unsigned Latency    = 38;

  localparam logic [1:0] CfgFullScale = 2'd0;
  localparam logic [1:0] CfgDeadGap   = 2'd1;
  localparam logic [1:0] CfgScale     = 2'd2;

  localparam logic [3:0] DirCenter    = 4'd0;
  localparam logic [3:0] DirLeft      = 4'd1;
  localparam logic [3:0] DirRight     = 4'd2;
  localparam logic [3:0] DirUp        = 4'd3;
  localparam logic [3:0] DirDown      = 4'd4;
  localparam logic [3:0] DirUpLeft    = 4'd5;
  localparam logic [3:0] DirUpRight   = 4'd6;
  localparam logic [3:0] DirDownLeft  = 4'd7;
  localparam logic [3:0] DirDownRight = 4'd8;

  localparam logic [12:0] IntensityMax = 13'd8191;
  localparam logic [12:0] DiagCap      = 13'd100;
  localparam logic [13:0] DiagFactorSq = 14'd9025;
  localparam logic [6:0]  Percent      = 7'd100;

  typedef struct packed {
    logic [11:0] x_sample;
    logic [11:0] y_sample;
  } req_t;

  typedef struct packed {
    logic [3:0]  direction;
    logic [12:0] intensity;
  } rsp_t;

  // sideband through the square-root cells
  typedef struct packed {
    logic        valid;
    logic [3:0]  dir;
    logic [18:0] card;
  } sq_side_t;

  typedef struct packed {
    sq_side_t    side;
    logic [39:0] rad;
    logic [21:0] rem;
    logic [19:0] root;
  } sqrt_t;

  // sideband through the divider cells
  typedef struct packed {
    logic       valid;
    logic [3:0] dir;
    logic       sat;
  } dv_side_t;

  typedef struct packed {
    dv_side_t    side;
    logic [11:0] rem;
    logic [12:0] low;
    logic [12:0] quo;
  } div_t;

endpackage

// File: rtl/core/jdi_sqrt_cell.sv
// one digit cell of the integer square root chain
// depends on jdi_pkg
module jdi_sqrt_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jdi_pkg::sqrt_t cell_i,
  output jdi_pkg::sqrt_t cell_o
);

  logic [23:0] wide;
  logic [23:0] trial;
  logic        valid_q;
  jdi_pkg::sqrt_t cell_d, cell_q;

  always_comb begin
    wide   = {cell_i.rem, cell_i.rad[39:38]};
    trial  = {2'b00, cell_i.root, 2'b01};
    cell_d = cell_i;
    cell_d.rad = {cell_i.rad[37:0], 2'b00};
    if (wide >= trial) begin
      cell_d.rem  = 22'(wide - trial);
      cell_d.root = {cell_i.root[18:0], 1'b1};
    end else begin
      cell_d.rem  = wide[21:0];
      cell_d.root = {cell_i.root[18:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_d.side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_comb begin
    cell_o            = cell_q;
    cell_o.side.valid = valid_q;
  end

endmodule

// File: rtl/core/jdi_div_cell.sv
// one quotient-bit cell of the restoring divider chain
// depends on jdi_pkg
module jdi_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [11:0]   scale_i,
  input  jdi_pkg::div_t cell_i,
  output jdi_pkg::div_t cell_o
);

  logic [12:0] wide;
  logic        valid_q;
  jdi_pkg::div_t cell_d, cell_q;

  always_comb begin
    wide   = {cell_i.rem, cell_i.low[12]};
    cell_d = cell_i;
    cell_d.low = {cell_i.low[11:0], 1'b0};
    if (wide >= {1'b0, scale_i}) begin
      cell_d.rem = 12'(wide - {1'b0, scale_i});
      cell_d.quo = {cell_i.quo[11:0], 1'b1};
    end else begin
      cell_d.rem = wide[11:0];
      cell_d.quo = {cell_i.quo[11:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_d.side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_comb begin
    cell_o            = cell_q;
    cell_o.side.valid = valid_q;
  end

endmodule

// File: rtl/core/joystick_direction_intensity.sv
// joystick dead zone, eight-way direction and intensity, top level
// depends on jdi_pkg, jdi_sqrt_cell, jdi_div_cell
//
// channel  | ports                              | handshake
// request  | start_i, req_i                     | taken when start_i && !busy_o
// result   | done_o, rsp_o                      | one-cycle strobe, no stall
// config   | cfg_we_i, cfg_idx_i, cfg_data_i    | written when cfg_we_i
//
// a request may enter every cycle; busy_o stays low
// each result passes through three front stages,
// 20 square-root cells, one load stage, 13 divider cells, one output stage
// reset clears the registers to their defaults and empties the pipe
module joystick_direction_intensity (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  jdi_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output jdi_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [11:0]   cfg_data_i
);

  logic [11:0] full_scale_q;
  logic [10:0] dead_gap_q;
  logic [11:0] scale_q;
  logic [11:0] scale;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= 12'd1023;
      dead_gap_q   <= 11'd50;
      scale_q      <= 12'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jdi_pkg::CfgFullScale: full_scale_q <= cfg_data_i;
        jdi_pkg::CfgDeadGap:   dead_gap_q   <= cfg_data_i[10:0];
        jdi_pkg::CfgScale:     scale_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign scale  = (scale_q == 12'd0) ? 12'd1 : scale_q;
  assign busy_o = 1'b0;

  // stage 0: deflection, dead zone, direction
  logic [11:0] center, mx, my, cmag;
  logic        xn, yn;
  logic [3:0]  dir;

  always_comb begin
    center = {1'b0, full_scale_q[11:1]};
    if (req_i.x_sample >= center) begin
      mx = req_i.x_sample - center;
      xn = 1'b0;
    end else begin
      mx = center - req_i.x_sample;
      xn = 1'b1;
    end
    if (mx <= {1'b0, dead_gap_q}) begin
      mx = '0;
      xn = 1'b0;
    end
    if (req_i.y_sample >= center) begin
      my = req_i.y_sample - center;
      yn = 1'b0;
    end else begin
      my = center - req_i.y_sample;
      yn = 1'b1;
    end
    if (my <= {1'b0, dead_gap_q}) begin
      my = '0;
      yn = 1'b0;
    end
    cmag = (mx != '0) ? mx : my;
    if (mx == '0 && my == '0) begin
      dir = jdi_pkg::DirCenter;
    end else if (my == '0) begin
      dir = xn ? jdi_pkg::DirLeft : jdi_pkg::DirRight;
    end else if (mx == '0) begin
      dir = yn ? jdi_pkg::DirDown : jdi_pkg::DirUp;
    end else if (!yn) begin
      dir = xn ? jdi_pkg::DirUpLeft : jdi_pkg::DirUpRight;
    end else begin
      dir = xn ? jdi_pkg::DirDownLeft : jdi_pkg::DirDownRight;
    end
  end

  logic        s0_valid_q;
  logic [3:0]  s0_dir_q;
  logic [11:0] s0_mx_q, s0_my_q, s0_cmag_q;

  // stage 1: squares and cardinal dividend
  logic        s1_valid_q;
  logic [3:0]  s1_dir_q;
  logic [24:0] s1_sumsq_q;
  logic [18:0] s1_card_q;

  // stage 2: radicand
  logic        s2_valid_q;
  logic [3:0]  s2_dir_q;
  logic [18:0] s2_card_q;
  logic [39:0] s2_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start_i && !busy_o;
      s1_valid_q <= s0_valid_q;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_dir_q   <= dir;
    s0_mx_q    <= mx;
    s0_my_q    <= my;
    s0_cmag_q  <= cmag;
    s1_dir_q   <= s0_dir_q;
    s1_sumsq_q <= 25'(24'(s0_mx_q) * 24'(s0_mx_q)) + 25'(24'(s0_my_q) * 24'(s0_my_q));
    s1_card_q  <= 19'(s0_cmag_q) * 19'(jdi_pkg::Percent);
    s2_dir_q   <= s1_dir_q;
    s2_card_q  <= s1_card_q;
    s2_rad_q   <= 40'(s1_sumsq_q) * 40'(jdi_pkg::DiagFactorSq);
  end

  // square-root chain
  jdi_pkg::sqrt_t sq_chain [jdi_pkg::SqrtCells+1];

  assign sq_chain[0] = '{side: '{valid: s2_valid_q, dir: s2_dir_q, card: s2_card_q},
                         rad: s2_rad_q, rem: '0, root: '0};

  for (genvar i = 0; i < jdi_pkg::SqrtCells; i++) begin : g_sqrt
    jdi_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (sq_chain[i]),
      .cell_o (sq_chain[i+1])
    );
  end

  // load stage: pick dividend, detect quotient overflow
  jdi_pkg::sqrt_t sq_last;
  logic           diag_in;
  logic [19:0]    num;
  logic           sat;
  logic           ld_valid_q;
  jdi_pkg::div_t  ld_d, ld_q;

  always_comb begin
    sq_last = sq_chain[jdi_pkg::SqrtCells];
    diag_in = sq_last.side.dir >= jdi_pkg::DirUpLeft;
    num     = diag_in ? sq_last.root : {1'b0, sq_last.side.card};
    sat     = {5'b0, num} >= {scale, 13'b0};
    ld_d.side.valid = sq_last.side.valid;
    ld_d.side.dir   = sq_last.side.dir;
    ld_d.side.sat   = sat;
    ld_d.rem        = {5'b0, num[19:13]};
    ld_d.low        = num[12:0];
    ld_d.quo        = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_valid_q <= 1'b0;
    end else begin
      ld_valid_q <= ld_d.side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_q <= ld_d;
  end

  // divider chain
  jdi_pkg::div_t dv_chain [jdi_pkg::DivCells+1];

  assign dv_chain[0] = '{side: '{valid: ld_valid_q, dir: ld_q.side.dir, sat: ld_q.side.sat},
                         rem: ld_q.rem, low: ld_q.low, quo: ld_q.quo};

  for (genvar j = 0; j < jdi_pkg::DivCells; j++) begin : g_div
    jdi_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .scale_i (scale),
      .cell_i  (dv_chain[j]),
      .cell_o  (dv_chain[j+1])
    );
  end

  // output stage
  jdi_pkg::div_t dv_last;
  logic [12:0]   inten;
  logic          done_q;
  jdi_pkg::rsp_t rsp_q;

  always_comb begin
    dv_last = dv_chain[jdi_pkg::DivCells];
    if (dv_last.side.dir == jdi_pkg::DirCenter) begin
      inten = '0;
    end else if (dv_last.side.dir >= jdi_pkg::DirUpLeft) begin
      inten = (dv_last.side.sat || dv_last.quo > jdi_pkg::DiagCap) ? jdi_pkg::DiagCap
                                                                   : dv_last.quo;
    end else begin
      inten = dv_last.side.sat ? jdi_pkg::IntensityMax : dv_last.quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_last.side.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q.direction <= dv_last.side.dir;
    rsp_q.intensity <= inten;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(jdi_pkg::Latency) done_o)
    else $error("result missing after request");
  a_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.direction == jdi_pkg::DirCenter |-> rsp_o.intensity == '0)
    else $error("center with nonzero intensity");
  a_diag_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.direction >= jdi_pkg::DirUpLeft |-> rsp_o.intensity <= jdi_pkg::DiagCap)
    else $error("diagonal intensity above cap");
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_valid_q |-> $past(sq_chain[jdi_pkg::SqrtCells].side.valid))
    else $error("divider load without square-root result");
`endif

endmodule

// File: bench/tb_joystick_direction_intensity.sv
// testbench for joystick_direction_intensity: directed table then random samples
// under several register settings, checked against an in-bench predictor
// depends on jdi_pkg and the joystick_direction_intensity rtl
`timescale 1ns / 1ps

module tb_joystick_direction_intensity;
  import jdi_pkg::*;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    bit          typed;
    logic [3:0]  dir;
    logic [12:0] inten;
  } sample_row_t;

  typedef struct {
    logic [11:0] full_scale;
    logic [11:0] dead_gap;
    logic [11:0] scale;
  } setting_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandItems  = 90;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  req_t        req_i = '0;
  logic        busy_o;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CfgFullScale;
  logic [11:0] cfg_data_i = '0;

  // shadow copy of the registers
  logic [11:0] sh_full_scale = 12'd1023;
  logic [10:0] sh_dead_gap   = 11'd50;
  logic [11:0] sh_scale      = 12'd512;

  rsp_t        pending_rsp[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;

  joystick_direction_intensity u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .done_o(done_o), .rsp_o(rsp_o),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_joystick_direction_intensity: errors");
      $finish;
    end
  end

  function automatic rsp_t predict_position(req_t r);
    longint unsigned center, scale, mx, my, q, rhs, t;
    bit xn, yn;
    rsp_t p;
    center = sh_full_scale >> 1;
    scale = (sh_scale != 0) ? sh_scale : 1;
    if (r.x_sample >= center) begin
      mx = r.x_sample - center; xn = 0;
    end else begin
      mx = center - r.x_sample; xn = 1;
    end
    if (mx <= sh_dead_gap) begin
      mx = 0; xn = 0;
    end
    if (r.y_sample >= center) begin
      my = r.y_sample - center; yn = 0;
    end else begin
      my = center - r.y_sample; yn = 1;
    end
    if (my <= sh_dead_gap) begin
      my = 0; yn = 0;
    end
    if (mx == 0 && my == 0) begin
      p.direction = DirCenter;
      p.intensity = '0;
    end else if (mx == 0 || my == 0) begin
      if (my == 0) p.direction = xn ? DirLeft : DirRight;
      else p.direction = yn ? DirDown : DirUp;
      q = ((mx == 0) ? my : mx) * 100 / scale;
      p.intensity = (q > IntensityMax) ? IntensityMax : q[12:0];
    end else begin
      if (!yn) p.direction = xn ? DirUpLeft : DirUpRight;
      else p.direction = xn ? DirDownLeft : DirDownRight;
      rhs = (mx * mx + my * my) * DiagFactorSq;
      q = 0;
      while (q < DiagCap) begin
        t = (q + 1) * scale;
        if (t * t > rhs) break;
        q++;
      end
      p.intensity = q[12:0];
    end
    return p;
  endfunction

  // result side: the block never waits, so every strobe is checked
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result dir=%0d intensity=%0d", rsp_o.direction, rsp_o.intensity);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        n_checked++;
        if (rsp_o.direction !== want.direction) begin
          $error("direction: expected %0d, got %0d", want.direction, rsp_o.direction);
          errors++;
        end
        if (rsp_o.intensity !== want.intensity) begin
          $error("intensity: expected %0d, got %0d", want.intensity, rsp_o.intensity);
          errors++;
        end
      end
    end
  end

  task automatic send_sample(logic [11:0] x, logic [11:0] y, bit typed, rsp_t typed_rsp);
    req_t r;
    rsp_t p;
    r.x_sample = x;
    r.y_sample = y;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    p = predict_position(r);
    if (typed && p != typed_rsp) begin
      $error("table row x=%0d y=%0d disagrees with predictor", x, y);
      errors++;
    end
    pending_rsp.push_back(typed ? typed_rsp : p);
    n_sent++;
  endtask

  task automatic drain_pipe();
    start_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (Latency + 3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgFullScale: sh_full_scale = data;
      CfgDeadGap:   sh_dead_gap = data[10:0];
      CfgScale:     sh_scale = data;
      default: ;
    endcase
  endtask

  function automatic logic [11:0] pick_sample();
    int v, c, g;
    c = sh_full_scale >> 1;
    g = sh_dead_gap;
    case ($urandom_range(4))
      0: v = $urandom_range(4095);
      1: v = c + $signed($urandom_range(40)) - 20;
      2: v = $urandom_range(1) ? 4095 : 0;
      3: v = $urandom_range(1) ? c + g + $urandom_range(2) - 1 : c - g + $urandom_range(2) - 1;
      default: v = c + $signed($urandom_range(1000)) - 500;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  sample_row_t table_rows[] = '{
    '{12'd511,  12'd511,  1'b1, DirCenter, 13'd0},
    '{12'd561,  12'd511,  1'b1, DirCenter, 13'd0},
    '{12'd562,  12'd511,  1'b1, DirRight,  13'd9},
    '{12'd460,  12'd511,  1'b1, DirLeft,   13'd9},
    '{12'd0,    12'd511,  1'b1, DirLeft,   13'd99},
    '{12'd4095, 12'd511,  1'b1, DirRight,  13'd700},
    '{12'd511,  12'd4095, 1'b1, DirUp,     13'd700},
    '{12'd511,  12'd0,    1'b1, DirDown,   13'd99},
    '{12'd4095, 12'd4095, 1'b1, DirUpRight, 13'd100},
    '{12'd0,    12'd4095, 1'b0, DirCenter, 13'd0},
    '{12'd0,    12'd0,    1'b0, DirCenter, 13'd0},
    '{12'd4095, 12'd0,    1'b0, DirCenter, 13'd0},
    '{12'd562,  12'd562,  1'b0, DirCenter, 13'd0},
    '{12'd460,  12'd460,  1'b0, DirCenter, 13'd0},
    '{12'd2730, 12'd1365, 1'b0, DirCenter, 13'd0},
    '{12'd1000, 12'd200,  1'b0, DirCenter, 13'd0}
  };

  setting_t settings[] = '{
    '{12'd1023, 12'd50,   12'd512},
    '{12'd4095, 12'd2047, 12'd4095},
    '{12'd0,    12'd0,    12'd64},
    '{12'd1,    12'd0,    12'd0},
    '{12'd4095, 12'd0,    12'd1},
    '{12'd2048, 12'd2055, 12'd100},
    '{12'd1023, 12'd5,    12'd300},
    '{12'd3000, 12'd200,  12'd2000}
  };

  initial begin
    rsp_t typed_rsp;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at the reset settings
    idle_pct = 12;
    foreach (table_rows[i]) begin
      typed_rsp.direction = table_rows[i].dir;
      typed_rsp.intensity = table_rows[i].inten;
      send_sample(table_rows[i].x, table_rows[i].y, table_rows[i].typed, typed_rsp);
    end

    foreach (settings[s]) begin
      // sender holds off until the pipe is empty before each register change
      drain_pipe();
      write_reg(CfgFullScale, settings[s].full_scale);
      write_reg(CfgDeadGap, settings[s].dead_gap);
      write_reg(CfgScale, settings[s].scale);
      idle_pct = (s < 3) ? 12 : (s < 6) ? 84 : 0;
      repeat (RandItems) send_sample(pick_sample(), pick_sample(), 1'b0, typed_rsp);
    end

    drain_pipe();
    if (pending_rsp.size() != 0) begin
      $error("%0d expected results never arrived", pending_rsp.size());
      errors++;
    end
    $display("covered %0d requests over %0d register settings, %0d results checked",
             n_sent, settings.size() + 1, n_checked);
    if (errors == 0) begin
      $display("tb_joystick_direction_intensity: clean");
    end else begin
      $display("tb_joystick_direction_intensity: errors");
    end
    $finish;
  end

endmodule
